// ===== rtl/core/vpa_pkg.sv =====
// Shared types and constants for the variable partition allocator.
// Used by the controller, the datapath and the top level.
package vpa_pkg;

  localparam int MODE_W  = 2;
  localparam int REQ_W   = 20;
  localparam int TGT_W   = 6;
  localparam int IDX_W   = 6;
  localparam int ESIZE_W = 20;
  localparam int CFG_W   = 20;
  localparam int SDATA_W = 32;
  localparam int MDATA_W = 32;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_SHOW  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT     = 1'b0;
  localparam logic REG_MEMSIZE = 1'b1;

  localparam logic [CFG_W-1:0] DEF_MEM_SIZE = 20'd65536;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_SPLIT_LO, S_SPLIT_HI,
    S_FREE_RD, S_FREE_CHK, S_CMP_RD, S_CMP_EV, S_CMP_FIN,
    S_LIST_INIT, S_LIST_RD, S_LIST_LD, S_FAIL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_SCAN, OP_DECIDE, OP_SHIFT_RD, OP_SHIFT_WR,
    OP_SPLIT_LO, OP_SPLIT_HI, OP_FREE_RD, OP_FREE_CHK, OP_CMP_EV, OP_CMP_FIN,
    OP_LIST_INIT, OP_LIST_LD, OP_FAIL
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic fail;
    logic exact;
    logic full;
    logic shift_done;
    logic free_ok;
    logic ev_hold;
    logic cmp_more;
    logic out_free;
    logic list_last;
  } stat_t;

endpackage

// ===== rtl/core/vpa_ctrl.sv =====
// Sequencer for the allocator: scan, split, merge and list phases.
// Depends on vpa_pkg; drives vpa_dp through cmd_t and reads stat_t.
module vpa_ctrl import vpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [MODE_W-1:0]   mode,
  input  stat_t               st,
  output logic                s_tready,
  output cmd_t                cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_ACCEPT;
          case (mode)
            MODE_ALLOC: state_next = S_SCAN;
            MODE_FREE:  state_next = S_FREE_RD;
            MODE_SHOW:  state_next = S_LIST_INIT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (st.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (st.fail || (!st.exact && st.full)) state_next = S_FAIL;
        else if (st.exact) state_next = S_LIST_INIT;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (st.shift_done) begin
          state_next = S_SPLIT_LO;
        end else begin
          cmd.op     = OP_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.op     = OP_SHIFT_WR;
        state_next = S_SHIFT_RD;
      end
      S_SPLIT_LO: begin
        cmd.op     = OP_SPLIT_LO;
        state_next = S_SPLIT_HI;
      end
      S_SPLIT_HI: begin
        cmd.op     = OP_SPLIT_HI;
        state_next = S_LIST_INIT;
      end
      S_FREE_RD: begin
        cmd.op     = OP_FREE_RD;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.op     = OP_FREE_CHK;
        state_next = st.free_ok ? S_CMP_RD : S_LIST_INIT;
      end
      S_CMP_RD: begin
        state_next = S_CMP_EV;
      end
      S_CMP_EV: begin
        cmd.op = OP_CMP_EV;
        if (st.ev_hold) state_next = S_CMP_EV;
        else if (st.cmp_more) state_next = S_CMP_RD;
        else state_next = S_CMP_FIN;
      end
      S_CMP_FIN: begin
        cmd.op     = OP_CMP_FIN;
        state_next = S_LIST_INIT;
      end
      S_LIST_INIT: begin
        cmd.op     = OP_LIST_INIT;
        state_next = S_LIST_RD;
      end
      S_LIST_RD: begin
        state_next = S_LIST_LD;
      end
      S_LIST_LD: begin
        cmd.op = OP_LIST_LD;
        if (st.out_free) state_next = st.list_last ? S_IDLE : S_LIST_RD;
      end
      S_FAIL: begin
        cmd.op = OP_FAIL;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/vpa_dp.sv =====
// Datapath for the allocator: block table memory, scan, shift, merge
// and the output register. Depends on vpa_pkg; sequenced by vpa_ctrl.
module vpa_dp import vpa_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [REQ_W-1:0]   request_size,
  input  logic [TGT_W-1:0]   target_block,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               m_tready,
  output stat_t              st,
  output logic               out_valid,
  output logic               out_status,
  output logic [IDX_W-1:0]   out_index,
  output logic [ESIZE_W-1:0] out_size,
  output logic               out_used,
  output logic               out_last
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [SIZE_BITS-1:0] RST_SIZE = SIZE_BITS'(DEF_MEM_SIZE);

  // entry layout: {used, size}
  logic [SIZE_BITS:0]   mem [MAX_BLOCKS];
  logic [SIZE_BITS:0]   rd_q;
  logic [IW-1:0]        rd_addr, wa;
  logic [SIZE_BITS:0]   wd;
  logic                 we;

  logic [CW-1:0]        cnt, i, w;
  logic [IW-1:0]        pick, di;
  logic [SIZE_BITS-1:0] best, req, acc;
  logic                 req_bad, found, v, accv, zr;
  logic [1:0]           policy;
  logic [TGT_W-1:0]     tgt;
  logic [CW-1:0]        im1;
  logic                 hit, upd, ld_list, ld_fail;

  assign im1 = i - CW'(1);
  assign hit = !rd_q[SIZE_BITS] && (rd_q[SIZE_BITS-1:0] >= req);
  assign upd = !found
             || (policy == FIT_BEST  && rd_q[SIZE_BITS-1:0] < best)
             || (policy == FIT_WORST && rd_q[SIZE_BITS-1:0] > best);

  always_comb begin
    st.scan_done  = (i == cnt) && !v;
    st.fail       = !found || req_bad || (req == '0);
    st.exact      = (best == req);
    st.full       = (cnt >= CW'(MAX_BLOCKS));
    st.shift_done = (i == (CW'(pick) + CW'(1)));
    st.free_ok    = (int'(tgt) < int'(cnt)) && rd_q[SIZE_BITS];
    st.ev_hold    = rd_q[SIZE_BITS] && accv;
    st.cmp_more   = ((i + CW'(1)) < cnt);
    st.out_free   = !out_valid || m_tready;
    st.list_last  = ((i + CW'(1)) == cnt);
  end

  assign ld_list = (cmd.op == OP_LIST_LD) && st.out_free;
  assign ld_fail = (cmd.op == OP_FAIL) && st.out_free;

  always_comb begin
    rd_addr = i[IW-1:0];
    we      = 1'b0;
    wa      = pick;
    wd      = rd_q;
    case (cmd.op)
      OP_DECIDE: begin
        we = !st.fail && st.exact;
        wd = {1'b1, req};
      end
      OP_SHIFT_RD: rd_addr = im1[IW-1:0];
      OP_SHIFT_WR: begin
        we = 1'b1;
        wa = i[IW-1:0];
      end
      OP_SPLIT_LO: begin
        we = 1'b1;
        wa = pick + IW'(1);
        wd = {1'b0, best - req};
      end
      OP_SPLIT_HI: begin
        we = 1'b1;
        wd = {1'b1, req};
      end
      OP_FREE_RD: rd_addr = IW'(tgt);
      OP_FREE_CHK: begin
        we = st.free_ok;
        wa = IW'(tgt);
        wd = {1'b0, rd_q[SIZE_BITS-1:0]};
      end
      OP_CMP_EV: begin
        we = rd_q[SIZE_BITS];
        wa = w[IW-1:0];
        wd = accv ? {1'b0, acc} : rd_q;
      end
      OP_CMP_FIN: begin
        we = accv;
        wa = w[IW-1:0];
        wd = {1'b0, acc};
      end
      default: ;
    endcase
    if (cfg_we && cfg_index == REG_MEMSIZE) begin
      we = 1'b1;
      wa = '0;
      wd = {1'b0, SIZE_BITS'(cfg_data)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= (zr && rd_addr == '0) ? {1'b0, RST_SIZE} : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= CW'(1);
      zr        <= 1'b1;
      policy    <= '0;
      out_valid <= 1'b0;
      v         <= 1'b0;
      found     <= 1'b0;
      accv      <= 1'b0;
    end else begin
      if (we && wa == '0) zr <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_FIT) policy <= cfg_data[1:0];
        else cnt <= CW'(1);
      end
      if (ld_list || ld_fail) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          v     <= 1'b0;
          found <= 1'b0;
          accv  <= 1'b0;
        end
        OP_SCAN: begin
          v <= (i < cnt);
          if (v && hit) found <= 1'b1;
        end
        OP_SPLIT_HI: cnt <= cnt + CW'(1);
        OP_FREE_CHK: accv <= 1'b0;
        OP_CMP_EV: begin
          if (!rd_q[SIZE_BITS]) accv <= 1'b1;
          else accv <= 1'b0;
        end
        OP_CMP_FIN: cnt <= accv ? w + CW'(1) : w;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        req     <= SIZE_BITS'(request_size);
        req_bad <= ((32'(request_size) >> SIZE_BITS) != 32'd0);
        tgt     <= target_block;
        i       <= '0;
      end
      OP_SCAN: begin
        if (i < cnt) begin
          di <= i[IW-1:0];
          i  <= i + CW'(1);
        end
        if (v && hit && upd) begin
          pick <= di;
          best <= rd_q[SIZE_BITS-1:0];
        end
      end
      OP_DECIDE:   i <= cnt;
      OP_SHIFT_WR: i <= im1;
      OP_FREE_CHK: begin
        i <= '0;
        w <= '0;
      end
      OP_CMP_EV: begin
        if (!rd_q[SIZE_BITS]) begin
          acc <= accv ? acc + rd_q[SIZE_BITS-1:0] : rd_q[SIZE_BITS-1:0];
          i   <= i + CW'(1);
        end else if (accv) begin
          w <= w + CW'(1);
        end else begin
          w <= w + CW'(1);
          i <= i + CW'(1);
        end
      end
      OP_LIST_INIT: i <= '0;
      default: ;
    endcase
    if (ld_list) begin
      out_status <= 1'b0;
      out_index  <= IDX_W'(i);
      out_size   <= ESIZE_W'(rd_q[SIZE_BITS-1:0]);
      out_used   <= rd_q[SIZE_BITS];
      out_last   <= st.list_last;
      i          <= i + CW'(1);
    end
    if (ld_fail) begin
      out_status <= 1'b1;
      out_index  <= '0;
      out_size   <= '0;
      out_used   <= 1'b0;
      out_last   <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/variable_partition_allocator_unit.sv =====
// Top level of the variable partition allocator.
// Instantiates vpa_ctrl and vpa_dp; depends on vpa_pkg.
//
// Keeps an ordered table of memory blocks in a single-port-write,
// registered-read memory and serves one request at a time. After the
// accepting cycle, an allocate scans the table and decides; a split
// then shifts each later entry up by one and writes the two halves. A
// free reads and checks the target, then runs a merge pass over the
// table, holding on each used entry that closes a free run, and
// finishes. Listing starts, then sends each table entry as one transfer
// while the output side keeps up. The table is read once per cycle, and
// that paces every phase. The input is taken only between requests.
module variable_partition_allocator_unit import vpa_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,   // mode, request_size, target_block
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,   // entry_index, entry_size, entry_used
  output logic               m_tuser,   // status
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cmd_t               cmd;
  stat_t              st;
  logic [IDX_W-1:0]   out_index;
  logic [ESIZE_W-1:0] out_size;
  logic               out_used;

  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tdata[MODE_W-1:0]),
    .st       (st),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  vpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request_size (s_tdata[MODE_W +: REQ_W]),
    .target_block (s_tdata[MODE_W+REQ_W +: TGT_W]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .m_tready     (m_tready),
    .st           (st),
    .out_valid    (m_tvalid),
    .out_status   (m_tuser),
    .out_index    (out_index),
    .out_size     (out_size),
    .out_used     (out_used),
    .out_last     (m_tlast)
  );

  assign m_tdata = {(MDATA_W - IDX_W - ESIZE_W - 1)'(0), out_used, out_size, out_index};

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("cannot-allocate result without last");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("cannot-allocate result carries data");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[MODE_W-1:0] != MODE_NOP) |=> !s_tready)
    else $error("second request taken while one is in progress");

endmodule
